@@ rtl/nls_pkg.sv @@
// ----------------------------------------------------------------------------
// Numeric literal scanner package
// Beat types, scan modes, literal kinds and character codes shared by the
// scanner step logic and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nls_pkg;

  // Input beat: one source character or the end-of-text marker.
  typedef struct packed {
    logic [7:0] character;
    logic       text_end;
  } in_t;

  // Output beat: one finished literal.
  typedef struct packed {
    logic [15:0] value;
    logic [2:0]  kind;
    logic        char_returned;
  } out_t;

  typedef enum logic [5:0] {
    MODE_START     = 6'b000001,
    MODE_BACKSLASH = 6'b000010,
    MODE_ESC_HEX   = 6'b000100,
    MODE_ZERO      = 6'b001000,
    MODE_HEX       = 6'b010000,
    MODE_DEC       = 6'b100000
  } mode_e;

  localparam logic [2:0] KIND_DEC     = 3'd0;
  localparam logic [2:0] KIND_HEX     = 3'd1;
  localparam logic [2:0] KIND_ESC     = 3'd2;
  localparam logic [2:0] KIND_ZERO    = 3'd3;
  localparam logic [2:0] KIND_INVALID = 3'd4;

  localparam logic [15:0] INVALID_VALUE = 16'hFFFF;
  localparam logic [15:0] ESC_HEX_MASK  = 16'h00FF;

  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_NINE      = 8'h39;
  localparam logic [7:0] CHAR_UC_A      = 8'h41;
  localparam logic [7:0] CHAR_UC_F      = 8'h46;
  localparam logic [7:0] CHAR_LC_A      = 8'h61;
  localparam logic [7:0] CHAR_LC_F      = 8'h66;
  localparam logic [7:0] CHAR_LC_N      = 8'h6E;
  localparam logic [7:0] CHAR_LC_R      = 8'h72;
  localparam logic [7:0] CHAR_LC_T      = 8'h74;
  localparam logic [7:0] CHAR_LC_X      = 8'h78;
  localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
  localparam logic [7:0] CHAR_SQUOTE    = 8'h27;

  localparam logic [15:0] CODE_NEWLINE = 16'h000A;
  localparam logic [15:0] CODE_CR      = 16'h000D;
  localparam logic [15:0] CODE_TAB     = 16'h0009;
  localparam logic [15:0] CODE_DQUOTE  = 16'h0022;
  localparam logic [15:0] CODE_SQUOTE  = 16'h0027;

endpackage

`default_nettype wire

@@ rtl/nls_step.sv @@
// ----------------------------------------------------------------------------
// Numeric literal scanner step
// Combinational next state of the scanner for one character: new mode,
// new accumulator, and the finished literal when this character ends one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nls_step
  import nls_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 16
) (
  input  mode_e                 mode_i,
  input  logic [VALUE_BITS-1:0] acc_i,
  input  in_t                   item_i,
  output mode_e                 mode_o,
  output logic [VALUE_BITS-1:0] acc_o,
  output logic                  emit_o,
  output out_t                  result_o
);

  logic [7:0]            c;
  logic                  at_end;
  logic                  is_dec;
  logic                  is_uc;
  logic                  is_lc;
  logic                  is_hex;
  logic [3:0]            digit;
  logic [31:0]           acc_ext;
  logic [15:0]           acc_low;
  logic [VALUE_BITS-1:0] dec_next;
  logic [VALUE_BITS-1:0] hex_next;

  assign c       = item_i.character;
  assign at_end  = item_i.text_end;
  assign is_dec  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  assign is_uc   = (c >= CHAR_UC_A) && (c <= CHAR_UC_F);
  assign is_lc   = (c >= CHAR_LC_A) && (c <= CHAR_LC_F);
  assign is_hex  = is_dec || is_uc || is_lc;
  assign acc_ext = 32'(acc_i);
  assign acc_low = acc_ext[15:0];

  always_comb begin
    digit = 4'd0;
    if (is_dec) begin
      digit = 4'(c - CHAR_ZERO);
    end else if (is_uc) begin
      digit = 4'(c - CHAR_UC_A + 8'd10);
    end else if (is_lc) begin
      digit = 4'(c - CHAR_LC_A + 8'd10);
    end
  end

  // Times ten as two shifts and an add; the sum wraps at the accumulator width.
  assign dec_next = (acc_i << 3) + (acc_i << 1) + VALUE_BITS'(digit);
  assign hex_next = (acc_i << 4) | VALUE_BITS'(digit);

  always_comb begin
    mode_o   = mode_i;
    acc_o    = acc_i;
    emit_o   = 1'b0;
    result_o = '{value: INVALID_VALUE, kind: KIND_INVALID, char_returned: 1'b0};

    unique case (mode_i)
      MODE_BACKSLASH: begin
        emit_o = 1'b1;
        if (!at_end) begin
          unique case (c)
            CHAR_LC_N:   result_o = '{value: CODE_NEWLINE, kind: KIND_ESC, char_returned: 1'b0};
            CHAR_LC_R:   result_o = '{value: CODE_CR, kind: KIND_ESC, char_returned: 1'b0};
            CHAR_LC_T:   result_o = '{value: CODE_TAB, kind: KIND_ESC, char_returned: 1'b0};
            CHAR_DQUOTE: result_o = '{value: CODE_DQUOTE, kind: KIND_ESC, char_returned: 1'b0};
            CHAR_SQUOTE: result_o = '{value: CODE_SQUOTE, kind: KIND_ESC, char_returned: 1'b0};
            CHAR_LC_X: begin
              emit_o = 1'b0;
              mode_o = MODE_ESC_HEX;
              acc_o  = '0;
            end
            default: ;
          endcase
        end
      end
      MODE_ESC_HEX, MODE_HEX: begin
        if (!at_end && is_hex) begin
          acc_o = hex_next;
        end else begin
          emit_o = 1'b1;
          if (mode_i == MODE_ESC_HEX) begin
            result_o = '{value: acc_low & ESC_HEX_MASK, kind: KIND_ESC,
                         char_returned: ~at_end};
          end else begin
            result_o = '{value: acc_low, kind: KIND_HEX, char_returned: ~at_end};
          end
        end
      end
      MODE_ZERO: begin
        if (!at_end && c == CHAR_LC_X) begin
          mode_o = MODE_HEX;
          acc_o  = '0;
        end else begin
          emit_o   = 1'b1;
          result_o = '{value: 16'h0000, kind: KIND_ZERO, char_returned: ~at_end};
        end
      end
      MODE_DEC: begin
        if (!at_end && is_dec) begin
          acc_o = dec_next;
        end else begin
          emit_o   = 1'b1;
          result_o = '{value: acc_low, kind: KIND_DEC, char_returned: ~at_end};
        end
      end
      default: begin
        // Start state: a backslash, a zero or a nonzero digit opens a literal.
        if (at_end) begin
          emit_o = 1'b1;
        end else if (c == CHAR_BACKSLASH) begin
          mode_o = MODE_BACKSLASH;
          acc_o  = '0;
        end else if (c == CHAR_ZERO) begin
          mode_o = MODE_ZERO;
          acc_o  = '0;
        end else if (is_dec) begin
          mode_o = MODE_DEC;
          acc_o  = VALUE_BITS'(digit);
        end else begin
          emit_o   = 1'b1;
          result_o = '{value: INVALID_VALUE, kind: KIND_INVALID, char_returned: 1'b1};
        end
      end
    endcase

    if (emit_o) begin
      mode_o = MODE_START;
      acc_o  = '0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/numeric_literal_scanner_top.sv @@
// ----------------------------------------------------------------------------
// Numeric literal scanner
// Scans C-style number literals from a character stream, one beat per cycle.
// ----------------------------------------------------------------------------
// The scanner takes one character beat per cycle and emits at most one
// literal beat per character: decimal, lone zero, 0x hex, or a backslash
// escape, with invalid starts and unknown escapes reported as the invalid
// kind. A beat is held in the input register; once the result register is
// free, the step logic updates the scan mode and accumulator and, when a
// literal ends, loads the result register. The sustained rate is one
// character per cycle; the input stalls only while a result waits
// unaccepted. When char_returned is set, the producer must present that
// character again.
`timescale 1ns / 1ps
`default_nettype none

module numeric_literal_scanner_top
  import nls_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic                  in_valid_q;
  in_t                   in_q;
  logic                  out_valid_q;
  out_t                  out_q;
  mode_e                 mode_q;
  mode_e                 mode_d;
  logic [VALUE_BITS-1:0] acc_q;
  logic [VALUE_BITS-1:0] acc_d;
  logic                  emit;
  out_t                  result;
  logic                  advance;

  // The held character moves on once the result register is free.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  nls_step #(
    .VALUE_BITS(VALUE_BITS)
  ) u_step (
    .mode_i  (mode_q),
    .acc_i   (acc_q),
    .item_i  (in_q),
    .mode_o  (mode_d),
    .acc_o   (acc_d),
    .emit_o  (emit),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_START;
      acc_q       <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        mode_q      <= mode_d;
        acc_q       <= acc_d;
        out_valid_q <= emit;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (advance && emit) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Every emitted literal leaves the scanner in the start state.
  a_start_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && emit |=> mode_q == MODE_START && acc_q == '0)
    else $error("scanner not back at start after a literal");

  // The invalid kind always carries the all-ones value.
  a_invalid_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_INVALID |-> out_data_o.value == INVALID_VALUE)
    else $error("invalid literal with a wrong value");

  // The end-of-text marker is never handed back.
  a_end_not_returned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && emit && in_q.text_end |-> !result.char_returned)
    else $error("end of text marked as returned");

  // With no character held, the input side never stalls.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_ready_o)
    else $error("input stalled while empty");

endmodule

`default_nettype wire
